@@ hw/rtl/double_hash_string_set_assert.svh @@
// assertion macros shared by the rtl files
`ifndef DOUBLE_HASH_STRING_SET_ASSERT_SVH
`define DOUBLE_HASH_STRING_SET_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only out of reset
`define DHSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// checked on every edge, reset included
`define DHSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`else

`define DHSS_ASSERT(lbl, clk, rst, prop)
`define DHSS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hw/rtl/dhss_pkg.sv @@
`default_nettype none

package dhss_pkg;

  localparam int TABLE_SIZE  = 4093;
  localparam int MAX_LETTERS = 12;
  localparam int LEN_W       = 4;
  localparam int LETTERS_W   = 24;
  localparam int SLOT_W      = 1 + LEN_W + LETTERS_W;
  localparam int POS_W       = $clog2(TABLE_SIZE);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [LEN_W-1:0]     length;
    logic [LETTERS_W-1:0] letters;
  } req_t;

  typedef struct packed {
    logic found;
    logic table_full;
  } rsp_t;

  typedef struct packed {
    logic                 valid;
    logic [LEN_W-1:0]     length;
    logic [LETTERS_W-1:0] letters;
  } slot_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] step;
  } hash_res_t;

  // clamp the length and clear letter bits beyond it
  function automatic slot_t make_slot(req_t r);
    logic [LEN_W-1:0]     len;
    logic [LETTERS_W-1:0] mask;
    slot_t                s;
    if (r.length == '0) begin
      len = LEN_W'(1);
    end else if (r.length > LEN_W'(MAX_LETTERS)) begin
      len = LEN_W'(MAX_LETTERS);
    end else begin
      len = r.length;
    end
    for (int i = 0; i < LETTERS_W; i++) begin
      mask[i] = (LEN_W'(i >> 1) < len);
    end
    s.valid   = 1'b1;
    s.length  = len;
    s.letters = r.letters & mask;
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dhss_ram.sv @@
`default_nettype none

module dhss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/dhss_hash.sv @@
`default_nettype none

`include "double_hash_string_set_assert.svh"

module dhss_hash import dhss_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire slot_t slot,
  output logic       done,
  output hash_res_t  res
);

  typedef enum logic {
    H_IDLE,
    H_KEY
  } state_t;

  localparam logic [POS_W+2:0] MOD1 = (POS_W+3)'(TABLE_SIZE);
  localparam logic [POS_W+2:0] MOD2 = (POS_W+3)'(TABLE_SIZE - 1);

  state_t               state;
  logic [LEN_W-1:0]     idx;
  logic [LETTERS_W-1:0] letters;
  logic [POS_W-1:0]     r1;
  logic [POS_W-1:0]     r2;

  logic [1:0]       code;
  logic [POS_W-1:0] r1_next;
  logic [POS_W-1:0] r2_next;

  // horner step on a residue: (r * 5 + code + 1) mod m, quotient at most 4
  function automatic logic [POS_W-1:0] fold5(logic [POS_W-1:0] r, logic [1:0] c,
                                            logic [POS_W+2:0] m);
    logic [POS_W+2:0] x;
    logic [POS_W+2:0] y;
    x = ({3'b000, r} << 2) + {3'b000, r} + (POS_W+3)'(c) + (POS_W+3)'(1);
    if (x >= (m << 2)) begin
      y = x - (m << 2);
    end else if (x >= ((m << 1) + m)) begin
      y = x - ((m << 1) + m);
    end else if (x >= (m << 1)) begin
      y = x - (m << 1);
    end else if (x >= m) begin
      y = x - m;
    end else begin
      y = x;
    end
    return y[POS_W-1:0];
  endfunction

  always_comb begin
    code    = letters[{idx, 1'b0} +: 2];
    r1_next = fold5(r1, code, MOD1);
    r2_next = fold5(r2, code, MOD2);
  end

  assign res.pos  = r1;
  assign res.step = r2 + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (start) begin
            r1      <= '0;
            r2      <= '0;
            idx     <= slot.length - LEN_W'(1);
            letters <= slot.letters;
            state   <= H_KEY;
          end
        end
        H_KEY: begin
          // last letter first, both residues kept reduced
          r1 <= r1_next;
          r2 <= r2_next;
          if (idx == '0) begin
            done  <= 1'b1;
            state <= H_IDLE;
          end else begin
            idx <= idx - LEN_W'(1);
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  `DHSS_ASSERT(a_hash_pos, clk, rst, done |-> (res.pos < POS_W'(TABLE_SIZE)))
  `DHSS_ASSERT(a_hash_step, clk, rst, done |-> (r2 < POS_W'(TABLE_SIZE - 1)))
  `DHSS_ASSERT(a_hash_start_idle, clk, rst, start |-> (state == H_IDLE))

endmodule

`default_nettype wire

@@ hw/rtl/dhss_probe.sv @@
`default_nettype none

`include "double_hash_string_set_assert.svh"

module dhss_probe import dhss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire op_e       op,
  input  wire slot_t     slot,
  input  wire hash_res_t hres,
  input  wire logic      res_ready,
  output logic           res_valid,
  output rsp_t           res,
  output logic           clearing
);

  typedef enum logic [2:0] {
    P_CLEAR,
    P_IDLE,
    P_READ,
    P_CMP,
    P_DONE
  } state_t;

  localparam logic [POS_W:0] SIZE_X = (POS_W+1)'(TABLE_SIZE);

  state_t           state;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] step;
  logic [POS_W-1:0] cnt;
  op_e              op_q;
  slot_t            slot_q;
  rsp_t             res_q;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             cur;
  logic [POS_W:0]    sum;
  logic              hit;
  logic              empty;

  dhss_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur   = slot_t'(ram_rdata);
    hit   = (cur == slot_q);
    empty = !cur.valid;
    sum   = {1'b0, pos} + {1'b0, step};
    if (state == P_CLEAR) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == P_CMP) && empty && (op_q == OP_INSERT);
      ram_wdata = slot_q;
    end
  end

  assign clearing  = (state == P_CLEAR);
  assign res_valid = (state == P_DONE);
  assign res       = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_CLEAR;
      pos   <= '0;
    end else begin
      unique case (state)
        P_CLEAR: begin
          if (pos == POS_W'(TABLE_SIZE - 1)) begin
            state <= P_IDLE;
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        P_IDLE: begin
          if (start) begin
            pos    <= hres.pos;
            step   <= hres.step;
            cnt    <= '0;
            op_q   <= op;
            slot_q <= slot;
            state  <= P_READ;
          end
        end
        P_READ: state <= P_CMP;
        P_CMP: begin
          if (hit) begin
            res_q <= '{found: 1'b1, table_full: 1'b0};
            state <= P_DONE;
          end else if (empty) begin
            res_q <= '{found: 1'b0, table_full: 1'b0};
            state <= P_DONE;
          end else if (cnt == POS_W'(TABLE_SIZE - 1)) begin
            res_q <= '{found: 1'b0, table_full: 1'b1};
            state <= P_DONE;
          end else begin
            pos   <= (sum >= SIZE_X) ? POS_W'(sum - SIZE_X) : POS_W'(sum);
            cnt   <= cnt + POS_W'(1);
            state <= P_READ;
          end
        end
        P_DONE: begin
          if (res_ready) begin
            state <= P_IDLE;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  `DHSS_ASSERT(a_probe_excl, clk, rst, res_valid |-> !(res.found && res.table_full))
  `DHSS_ASSERT(a_probe_start_idle, clk, rst, start |-> (state == P_IDLE))
  `DHSS_ASSERT(a_probe_pos_range, clk, rst, (state == P_READ) |-> (pos < POS_W'(TABLE_SIZE)))

endmodule

`default_nettype wire

@@ hw/rtl/double_hash_string_set.sv @@
// channel | direction | payload | handshake
// req     | in        | req_t   | req_valid / req_stall
// rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// one transaction in flight: a request is taken and hashed one letter a cycle
// (1 to 12 letters, both residues kept reduced as the letters come in), then the
// table is probed, each probe a read state then a compare state, as the ram read
// port is registered; a new request waits until the last result reaches the
// output register. after reset the table is swept clear, one slot a cycle, with
// req_stall high; a result sits in the output register while the next is taken
`default_nettype none

`include "double_hash_string_set_assert.svh"

module double_hash_string_set import dhss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // request capture
  logic  busy;
  op_e   op_q;
  slot_t slot_q;
  logic  hash_start;

  // output register
  logic out_valid;
  rsp_t out_data;

  logic      accept;
  logic      clearing;
  logic      hash_done;
  hash_res_t hres;
  logic      p_res_valid;
  rsp_t      p_res;
  logic      res_ready;

  assign req_stall = busy || clearing;
  assign accept    = req_valid && !req_stall;
  // output register free, or being emptied this cycle
  assign res_ready = !out_valid || !rsp_stall;
  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  dhss_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .slot  (slot_q),
    .done  (hash_done),
    .res   (hres)
  );

  dhss_probe u_probe (
    .clk       (clk),
    .rst       (rst),
    .start     (hash_done),
    .op        (op_q),
    .slot      (slot_q),
    .hres      (hres),
    .res_ready (res_ready),
    .res_valid (p_res_valid),
    .res       (p_res),
    .clearing  (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      hash_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      hash_start <= accept;
      if (accept) begin
        busy   <= 1'b1;
        op_q   <= req.op;
        // clamp length and mask stale letters before hashing and compare
        slot_q <= make_slot(req);
      end
      if (p_res_valid && res_ready) begin
        out_valid <= 1'b1;
        out_data  <= p_res;
        busy      <= 1'b0;
      end else if (out_valid && !rsp_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DHSS_ASSERT(a_top_accept_busy, clk, rst, accept |=> busy)
  `DHSS_ASSERT(a_top_result_lands, clk, rst, (p_res_valid && res_ready) |=> rsp_valid)
  `DHSS_ASSERT(a_top_no_accept_clear, clk, rst, clearing |-> !accept)

endmodule

`default_nettype wire

@@ dv/tb_double_hash_string_set.sv @@
`timescale 1ns / 100ps

module tb_double_hash_string_set;
  import dhss_pkg::*;

  localparam int DIR_ROWS    = 24;
  localparam int RAND_PER_PH = 215;
  // long output hold, well past the time one lookup takes
  localparam int HOLD_CYCLES = 400;
  // quiet cycles after the last result, more than one full-table probe run
  localparam int TAIL_CYCLES = 9000;

  // one row of the directed table; want_* only used where typed is set
  typedef struct packed {
    op_e                  op;
    logic [LEN_W-1:0]     length;
    logic [LETTERS_W-1:0] letters;
    bit                   typed;
    bit                   want_found;
    bit                   want_full;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  double_hash_string_set dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // shadow copy of the slot table and the results still owed by the block
  slot_t       shadow_table [TABLE_SIZE];
  int unsigned slots_used;
  rsp_t        awaited_rsps [$];
  req_t        kept_strings [$];
  stim_row_t   dir_rows [DIR_ROWS];

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_asks     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_count    = 0;

  int unsigned errors   = 0;
  int unsigned n_in     = 0;
  int unsigned n_out    = 0;
  int unsigned n_found  = 0;
  int unsigned n_full   = 0;

  // walk the double-hash probe sequence over the shadow table; an insert
  // fills the first empty slot it meets
  function automatic rsp_t hash_probe(req_t r);
    logic [LEN_W-1:0] len;
    slot_t            entry;
    longint unsigned  key;
    longint unsigned  weight;
    int unsigned      pos;
    int unsigned      stride;
    int unsigned      tries;
    bit               done;
    rsp_t             res;
    len = r.length;
    if (len == '0) begin
      len = LEN_W'(1);
    end else if (len > LEN_W'(MAX_LETTERS)) begin
      len = LEN_W'(MAX_LETTERS);
    end
    entry        = '0;
    entry.valid  = 1'b1;
    entry.length = len;
    key          = 0;
    weight       = 1;
    // letters past the length are dropped from both key and stored entry
    for (int p = 0; p < len; p++) begin
      entry.letters[2*p +: 2] = r.letters[2*p +: 2];
      key    += weight * (longint'(r.letters[2*p +: 2]) + 1);
      weight *= 5;
    end
    pos            = int'(key % TABLE_SIZE);
    stride         = 1 + int'(key % (TABLE_SIZE - 1));
    res.found      = 1'b0;
    res.table_full = 1'b1;
    done           = 1'b0;
    tries          = 0;
    while (!done && tries < TABLE_SIZE) begin
      if (shadow_table[pos] == entry) begin
        res.found      = 1'b1;
        res.table_full = 1'b0;
        done           = 1'b1;
      end else if (!shadow_table[pos].valid) begin
        if (r.op == OP_INSERT) begin
          shadow_table[pos] = entry;
          slots_used++;
        end
        res.table_full = 1'b0;
        done           = 1'b1;
      end else begin
        pos += stride;
        if (pos >= TABLE_SIZE) pos -= TABLE_SIZE;
        tries++;
      end
    end
    return res;
  endfunction

  // mostly fresh strings, a fair share of repeats of inserted ones with
  // junk above the length, now and then a length outside 1..12
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40 && kept_strings.size() != 0) begin
      r = kept_strings[$urandom_range(kept_strings.size() - 1)];
      if (r.length != '0 && r.length < LEN_W'(MAX_LETTERS)) begin
        r.letters = r.letters | (LETTERS_W'($urandom) << (2 * r.length));
      end
      r.op = ($urandom_range(3) == 0) ? OP_INSERT : OP_FIND;
    end else begin
      r.op      = ($urandom_range(1) == 0) ? OP_INSERT : OP_FIND;
      r.length  = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15))
                                           : LEN_W'($urandom_range(MAX_LETTERS, 1));
      r.letters = LETTERS_W'($urandom);
      if (r.op == OP_INSERT) kept_strings.push_back(r);
    end
    return r;
  endfunction

  // offer one transaction, with random idle gaps first; valid stays high on
  // return so a following offer can go back to back
  task automatic offer(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    // taken at this edge
    pred = hash_probe(r);
    awaited_rsps.push_back(typed ? want : pred);
    n_in++;
  endtask

  // drop valid and wait for every owed result
  task automatic pause_until_drained();
    req_valid <= 1'b0;
    while (awaited_rsps.size() != 0) @(posedge clk);
  endtask

  // result side: check at the edge, then choose the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      n_out++;
      if (awaited_rsps.size() == 0) begin
        $error("result with nothing owed: found=%0b table_full=%0b",
               rsp.found, rsp.table_full);
        errors++;
      end else begin
        if (rsp.found !== awaited_rsps[0].found) begin
          $error("found: expected %0b, actual %0b", awaited_rsps[0].found, rsp.found);
          errors++;
        end
        if (rsp.table_full !== awaited_rsps[0].table_full) begin
          $error("table_full: expected %0b, actual %0b",
                 awaited_rsps[0].table_full, rsp.table_full);
          errors++;
        end
        void'(awaited_rsps.pop_front());
      end
      if (rsp.found === 1'b1) n_found++;
      if (rsp.table_full === 1'b1) n_full++;
    end
    if (hold_asks != hold_seen) begin
      hold_seen  = hold_asks;
      hold_count = HOLD_CYCLES;
    end
    if (hold_count != 0) begin
      hold_count--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // overall time limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    req_t        r;
    rsp_t        want;

    // directed table: empty set, repeats, length zero and saturation,
    // junk above the length, a first-probe collision with "A"
    dir_rows[0]  = '{OP_FIND,   4'd1,  24'h000000, 1'b1, 1'b0, 1'b0};
    dir_rows[1]  = '{OP_INSERT, 4'd1,  24'h000000, 1'b1, 1'b0, 1'b0};
    dir_rows[2]  = '{OP_INSERT, 4'd1,  24'h000000, 1'b1, 1'b1, 1'b0};
    dir_rows[3]  = '{OP_FIND,   4'd1,  24'hFFFFFC, 1'b1, 1'b1, 1'b0};
    dir_rows[4]  = '{OP_INSERT, 4'd0,  24'h000000, 1'b1, 1'b1, 1'b0};
    dir_rows[5]  = '{OP_FIND,   4'd0,  24'h000003, 1'b1, 1'b0, 1'b0};
    dir_rows[6]  = '{OP_INSERT, 4'd12, 24'hFFFFFF, 1'b1, 1'b0, 1'b0};
    dir_rows[7]  = '{OP_FIND,   4'd15, 24'hFFFFFF, 1'b1, 1'b1, 1'b0};
    dir_rows[8]  = '{OP_FIND,   4'd13, 24'hFFFFFF, 1'b1, 1'b1, 1'b0};
    dir_rows[9]  = '{OP_FIND,   4'd11, 24'hFFFFFF, 1'b1, 1'b0, 1'b0};
    dir_rows[10] = '{OP_INSERT, 4'd12, 24'h000000, 1'b0, 1'b0, 1'b0};
    dir_rows[11] = '{OP_FIND,   4'd12, 24'h000000, 1'b1, 1'b1, 1'b0};
    dir_rows[12] = '{OP_INSERT, 4'd3,  24'hABCDE4, 1'b0, 1'b0, 1'b0};
    dir_rows[13] = '{OP_FIND,   4'd3,  24'h000024, 1'b1, 1'b1, 1'b0};
    dir_rows[14] = '{OP_INSERT, 4'd2,  24'h00000F, 1'b0, 1'b0, 1'b0};
    dir_rows[15] = '{OP_FIND,   4'd2,  24'h55550F, 1'b1, 1'b1, 1'b0};
    // key 4094 lands on the slot of "A" and must step on
    dir_rows[16] = '{OP_INSERT, 4'd6,  24'h00006B, 1'b0, 1'b0, 1'b0};
    dir_rows[17] = '{OP_FIND,   4'd6,  24'hFFF06B, 1'b1, 1'b1, 1'b0};
    dir_rows[18] = '{OP_INSERT, 4'd6,  24'hAAAAAA, 1'b0, 1'b0, 1'b0};
    dir_rows[19] = '{OP_FIND,   4'd7,  24'hAAAAAA, 1'b1, 1'b0, 1'b0};
    dir_rows[20] = '{OP_INSERT, 4'd14, 24'h555555, 1'b0, 1'b0, 1'b0};
    dir_rows[21] = '{OP_INSERT, 4'd1,  24'h000001, 1'b0, 1'b0, 1'b0};
    dir_rows[22] = '{OP_FIND,   4'd0,  24'h000001, 1'b1, 1'b1, 1'b0};
    dir_rows[23] = '{OP_FIND,   4'd8,  24'h123456, 1'b0, 1'b0, 1'b0};

    for (int s = 0; s < TABLE_SIZE; s++) shadow_table[s] = '0;
    slots_used = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // phase one: sender idles a little, receiver stalls a lot
    src_idle_pct  = 15;
    sink_idle_pct = 68;
    for (int k = 0; k < DIR_ROWS; k++) begin
      r.op            = dir_rows[k].op;
      r.length        = dir_rows[k].length;
      r.letters       = dir_rows[k].letters;
      want.found      = dir_rows[k].want_found;
      want.table_full = dir_rows[k].want_full;
      offer(r, dir_rows[k].typed, want);
    end
    repeat (RAND_PER_PH) offer(random_req(), 1'b0, '0);
    pause_until_drained();

    // phase two: the other way round
    src_idle_pct  = 68;
    sink_idle_pct = 15;
    repeat (RAND_PER_PH) offer(random_req(), 1'b0, '0);
    pause_until_drained();

    // phase three: no idling, opened by a long output hold so the block
    // backs up and stalls its request side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_asks++;
    repeat (RAND_PER_PH) offer(random_req(), 1'b0, '0);
    pause_until_drained();

    // nothing more may come out
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d transactions in, %0d results out, %0d hits, %0d full-table results",
             n_in, n_out, n_found, n_full);
    $display("run: directed corner rows, three idling mixes and a long output hold, %0d slots used",
             slots_used);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/dhss_pkg.sv
hw/rtl/dhss_ram.sv
hw/rtl/dhss_hash.sv
hw/rtl/dhss_probe.sv
hw/rtl/double_hash_string_set.sv
dv/tb_double_hash_string_set.sv
